[sv/fida_pkg.sv]
package fida_pkg;

	localparam int ID_W = 10;
	localparam int OWNER_W = 23;
	localparam logic [ID_W-1:0] RESET_MAX_ID = 10'd512;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NONE_FREE = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_UNUSED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_CLEAR
	} state_t;

	// classified command as it travels from front to back
	typedef struct packed {
		cmd_t               op;
		logic               id_zero;
		logic [ID_W-1:0]    id;
		logic [OWNER_W-1:0] owner;
	} item_t;

	typedef struct packed {
		logic               used;
		logic [OWNER_W-1:0] owner;
	} tab_word_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

[sv/fida_if.sv]
interface fida_cmd_if;
	logic                            valid;
	logic                            ready;
	fida_pkg::cmd_t                  cmd;
	logic [fida_pkg::ID_W-1:0]       id_in;
	logic [fida_pkg::OWNER_W-1:0]    owner_in;

	modport source (output valid, cmd, id_in, owner_in, input ready);
	modport sink (input valid, cmd, id_in, owner_in, output ready);
endinterface

interface fida_res_if;
	logic                            valid;
	logic                            ready;
	logic [fida_pkg::ID_W-1:0]       id_out;
	logic [fida_pkg::OWNER_W-1:0]    owner_out;
	logic                            in_use;
	fida_pkg::status_t               status;

	modport source (output valid, id_out, owner_out, in_use, status, input ready);
	modport sink (input valid, id_out, owner_out, in_use, status, output ready);
endinterface

interface fida_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fida_pkg::ID_W-1:0]       max_id;

	modport source (output valid, max_id, input ready);
	modport sink (input valid, max_id, output ready);
endinterface

[sv/fida_ram.sv]
module fida_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/fida_fifo.sv]
module fida_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fida_pkg::item_t push_data,
	output logic            full,
	input  logic            pop,
	output fida_pkg::item_t pop_data,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fida_pkg::item_t entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign full = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command queue read while empty");

endmodule

[sv/fida_front.sv]
module fida_front (
	fida_cmd_if.sink              cmd_ch,
	input  fida_pkg::back_stat_t  stat,
	input  logic                  full,
	output logic                  push,
	output fida_pkg::item_t       push_data
);

	// nothing is taken while the tables are being swept
	assign cmd_ch.ready = !full && !stat.clearing;
	assign push = cmd_ch.valid && cmd_ch.ready;

	always_comb begin
		push_data.op = cmd_ch.cmd;
		push_data.owner = cmd_ch.owner_in;
		case (cmd_ch.cmd)
			fida_pkg::CMD_FREE, fida_pkg::CMD_QUERY: begin
				push_data.id = cmd_ch.id_in;
				push_data.id_zero = (cmd_ch.id_in == '0);
			end
			default: begin
				push_data.id = '0;
				push_data.id_zero = 1'b1;
			end
		endcase
	end

endmodule

[sv/fida_back.sv]
module fida_back #(
	parameter int MAX_IDS = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  fida_pkg::item_t       item,
	output logic                  pop,
	fida_cfg_if.sink              cfg_ch,
	fida_res_if.source            res_ch,
	output fida_pkg::back_stat_t  stat
);

	localparam int PTR_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int TAB_AW = $clog2(MAX_IDS + 1);
	localparam int CNT_W = TAB_AW;
	localparam int ID_W = fida_pkg::ID_W;
	localparam int OWNER_W = fida_pkg::OWNER_W;
	localparam int TAB_W = $bits(fida_pkg::tab_word_t);
	localparam int LIM_RST = (512 > MAX_IDS) ? MAX_IDS : 512;

	fida_pkg::state_t    state_q, state_d;
	fida_pkg::item_t     item_q;
	logic [ID_W-1:0]     max_id_q;
	logic [CNT_W-1:0]    limit_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [TAB_AW-1:0]   clr_cnt_q;

	logic                res_valid_q;
	logic [ID_W-1:0]     res_id_q;
	logic [OWNER_W-1:0]  res_owner_q;
	logic                res_use_q;
	fida_pkg::status_t   res_stat_q;

	logic                q_we, q_re;
	logic [PTR_W-1:0]    q_waddr, q_raddr;
	logic [ID_W-1:0]     q_wdata, q_rdata;
	logic                t_we, t_re;
	logic [TAB_AW-1:0]   t_waddr, t_raddr;
	fida_pkg::tab_word_t t_wdata, t_rdata;
	logic [TAB_W-1:0]    t_rdata_raw;

	logic                out_free;
	logic                out_load;
	logic [ID_W-1:0]     out_id;
	logic [OWNER_W-1:0]  out_owner;
	logic                out_use;
	fida_pkg::status_t   out_stat;
	logic                id_ok;
	logic                clr_last;
	logic                do_alloc, do_release;
	logic [CNT_W-1:0]    limit_new;
	logic [PTR_W-1:0]    head_next, tail_next;

	fida_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	fida_ram #(.WIDTH(TAB_W), .DEPTH(MAX_IDS + 1)) u_table_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata_raw)
	);

	assign t_rdata = fida_pkg::tab_word_t'(t_rdata_raw);

	assign cfg_ch.ready = 1'b1;
	assign stat.clearing = (state_q == fida_pkg::S_CLEAR);

	assign res_ch.valid = res_valid_q;
	assign res_ch.id_out = res_id_q;
	assign res_ch.owner_out = res_owner_q;
	assign res_ch.in_use = res_use_q;
	assign res_ch.status = res_stat_q;

	assign out_free = !res_valid_q || res_ch.ready;
	assign id_ok = !item.id_zero && (32'(item.id) <= 32'(limit_q));
	assign clr_last = (clr_cnt_q == TAB_AW'(MAX_IDS));
	assign limit_new = (32'(max_id_q) > 32'(MAX_IDS)) ? CNT_W'(MAX_IDS) : CNT_W'(max_id_q);
	assign head_next = (head_q == PTR_W'(MAX_IDS - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == PTR_W'(MAX_IDS - 1)) ? '0 : tail_q + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fida_pkg::S_IDLE: begin
				if (item_valid && out_free) begin
					case (item.op)
						fida_pkg::CMD_INIT: state_d = fida_pkg::S_CLEAR;
						fida_pkg::CMD_ALLOC: begin
							if (count_q != '0) begin
								state_d = fida_pkg::S_EXEC;
							end
						end
						default: begin
							if (id_ok) begin
								state_d = fida_pkg::S_EXEC;
							end
						end
					endcase
				end
			end
			fida_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = fida_pkg::S_IDLE;
				end
			end
			fida_pkg::S_CLEAR: begin
				if (clr_last) begin
					state_d = fida_pkg::S_IDLE;
				end
			end
			default: state_d = fida_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		q_re = 1'b0;
		q_raddr = head_q;
		q_we = 1'b0;
		q_waddr = tail_q;
		q_wdata = item_q.id;
		t_re = 1'b0;
		t_raddr = TAB_AW'(item.id);
		t_we = 1'b0;
		t_waddr = TAB_AW'(item_q.id);
		t_wdata = '0;
		out_load = 1'b0;
		out_id = '0;
		out_owner = '0;
		out_use = 1'b0;
		out_stat = fida_pkg::STAT_OK;
		do_alloc = 1'b0;
		do_release = 1'b0;
		case (state_q)
			fida_pkg::S_IDLE: begin
				if (item_valid && out_free) begin
					pop = 1'b1;
					case (item.op)
						fida_pkg::CMD_INIT: out_load = 1'b1;
						fida_pkg::CMD_ALLOC: begin
							if (count_q == '0) begin
								out_load = 1'b1;
								out_stat = fida_pkg::STAT_NONE_FREE;
							end else begin
								q_re = 1'b1;
							end
						end
						default: begin
							if (!id_ok) begin
								out_load = 1'b1;
								out_stat = fida_pkg::STAT_RANGE;
							end else begin
								t_re = 1'b1;
							end
						end
					endcase
				end
			end
			fida_pkg::S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					case (item_q.op)
						fida_pkg::CMD_ALLOC: begin
							do_alloc = 1'b1;
							t_we = 1'b1;
							t_waddr = TAB_AW'(q_rdata);
							t_wdata.used = 1'b1;
							t_wdata.owner = item_q.owner;
							out_id = q_rdata;
						end
						fida_pkg::CMD_FREE: begin
							if (!t_rdata.used) begin
								out_stat = fida_pkg::STAT_UNUSED;
							end else begin
								do_release = 1'b1;
								t_we = 1'b1;
								q_we = (count_q < CNT_W'(MAX_IDS));
							end
						end
						default: begin
							out_use = t_rdata.used;
							out_owner = t_rdata.owner;
						end
					endcase
				end
			end
			fida_pkg::S_CLEAR: begin
				// sweep: tables to zero, queue slot i holds i+1
				t_we = 1'b1;
				t_waddr = clr_cnt_q;
				q_we = !clr_last;
				q_waddr = PTR_W'(clr_cnt_q);
				q_wdata = ID_W'(32'(clr_cnt_q) + 32'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fida_pkg::S_CLEAR;
			max_id_q <= fida_pkg::RESET_MAX_ID;
			limit_q <= CNT_W'(LIM_RST);
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			clr_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_ch.valid) begin
				max_id_q <= cfg_ch.max_id;
			end
			if (state_q == fida_pkg::S_IDLE && pop && item.op == fida_pkg::CMD_INIT) begin
				limit_q <= limit_new;
				clr_cnt_q <= '0;
			end
			if (state_q == fida_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_last) begin
					head_q <= '0;
					tail_q <= (limit_q == CNT_W'(MAX_IDS)) ? '0 : PTR_W'(limit_q);
					count_q <= limit_q;
				end
			end
			if (do_alloc) begin
				head_q <= head_next;
				count_q <= count_q - 1'b1;
			end
			if (q_we && do_release) begin
				tail_q <= tail_next;
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item;
		end
		if (out_load) begin
			res_id_q <= out_id;
			res_owner_q <= out_owner;
			res_use_q <= out_use;
			res_stat_q <= out_stat;
		end
	end

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fida_pkg::S_CLEAR) |-> (count_q <= limit_q))
		else $error("free count above limit");
	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fida_pkg::S_EXEC && item_q.op == fida_pkg::CMD_ALLOC) |-> (q_rdata != '0))
		else $error("free queue handed out identifier zero");
	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fida_pkg::S_CLEAR && clr_last) |=>
		(head_q == '0 && count_q == limit_q && state_q == fida_pkg::S_IDLE))
		else $error("queue not refilled at end of sweep");
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

endmodule

[sv/fifo_id_allocator_core.sv]
// commands pass a two-entry queue from the front end to the back end
// allocate, free and query in range pass through the exec state; out-of-range,
// empty-queue and init results are loaded from idle straight into the result register
// the back end takes no new command while one is in the exec state, which waits for the
// registered read of the free queue or entry table followed by its update
// after reset and after each init the back end sweeps MAX_IDS+1 table entries, one per
// cycle, with cmd_ch.ready low; max_id resets to 512 and takes effect at the next init
module fifo_id_allocator_core #(
	parameter int MAX_IDS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	fida_cmd_if.sink    cmd_ch,
	fida_cfg_if.sink    cfg_ch,
	fida_res_if.source  res_ch
);

	logic                 push, full, pop, empty;
	fida_pkg::item_t      push_data, pop_data;
	fida_pkg::back_stat_t stat;

	fida_front u_front (
		.cmd_ch    (cmd_ch),
		.stat      (stat),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	fida_fifo #(.DEPTH(2)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	fida_back #(.MAX_IDS(MAX_IDS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!empty),
		.item       (pop_data),
		.pop        (pop),
		.cfg_ch     (cfg_ch),
		.res_ch     (res_ch),
		.stat       (stat)
	);

endmodule
